// ----- rtl/lpd_pkg.sv -----
package lpd_pkg;

    // Defaults of the top-level parameters
    localparam int MAX_HISTORY_DEF = 256;
    localparam int OBS_LANES_DEF   = 8;

    // Fixed sizes
    localparam int NUM_ACTIONS = 2;
    localparam int NUM_FEATS   = 13;
    localparam int CNT_W       = 9;
    localparam int CNT_LIMIT   = 511;
    localparam int INV_W       = 17;
    localparam int FEAT_W      = 32;
    localparam int WEIGHT_W    = 18;
    localparam int PROD_W      = FEAT_W + WEIGHT_W;
    localparam int ACC_W       = 56;
    localparam int FRAC_W      = 16;
    localparam int SCORE_W     = 48;
    localparam int FIDX_W      = 4;

    localparam logic [INV_W-1:0]         INV_LEN_RESET = 17'd546;
    localparam logic signed [FEAT_W-1:0] BIAS_ONE      = 32'sd65536;

    // Feature positions, in issue order
    localparam logic [FIDX_W-1:0] FEAT_CHECK    = 4'd0;
    localparam logic [FIDX_W-1:0] FEAT_PROGRESS = 4'd1;
    localparam logic [FIDX_W-1:0] FEAT_REWARD   = 4'd2;
    localparam logic [FIDX_W-1:0] FEAT_COST     = 4'd3;
    localparam logic [FIDX_W-1:0] FEAT_OBS0     = 4'd4;
    localparam logic [FIDX_W-1:0] FEAT_OBS7     = 4'd11;
    localparam logic [FIDX_W-1:0] FEAT_BIAS     = 4'd12;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_PLAIN = 2'd1,
        EV_CHECK = 2'd2,
        EV_NEW   = 2'd3
    } lpd_event_t;

    typedef struct packed {
        logic signed [FEAT_W-1:0] obs_0;
        logic signed [FEAT_W-1:0] obs_1;
        logic signed [FEAT_W-1:0] obs_2;
        logic signed [FEAT_W-1:0] obs_3;
        logic signed [FEAT_W-1:0] obs_4;
        logic signed [FEAT_W-1:0] obs_5;
        logic signed [FEAT_W-1:0] obs_6;
        logic signed [FEAT_W-1:0] obs_7;
        logic signed [FEAT_W-1:0] episode_reward;
        logic signed [FEAT_W-1:0] episode_cost;
        lpd_event_t               history_event;
    } lpd_in_word_t;

    typedef struct packed {
        logic                      decision;
        logic signed [SCORE_W-1:0] score_pass;
        logic signed [SCORE_W-1:0] score_check;
    } lpd_out_word_t;

    // Control travelling alongside the feature into the MAC lanes
    typedef struct packed {
        logic              clear;
        logic              feat_vld;
        logic [FIDX_W-1:0] fidx;
    } lpd_lane_ctrl_t;

    // Learned weights, signed Q2.16, one row per action
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_ROM [NUM_ACTIONS][NUM_FEATS] = '{
        '{ 18'sd30858, -18'sd562, 18'sd73492, 18'sd71993, 18'sd621, 18'sd40731,
           18'sd443, 18'sd412, 18'sd122, 18'sd87, -18'sd517, 18'sd42020, 18'sd621 },
        '{ 18'sd31210, 18'sd999, 18'sd70235, 18'sd71880, 18'sd3877, 18'sd76369,
           18'sd2562, 18'sd3152, 18'sd520, 18'sd205, -18'sd3335, 18'sd78183,
           18'sd3877 }
    };

    function automatic logic signed [WEIGHT_W-1:0] lpd_weight(
        input logic              act,
        input logic [FIDX_W-1:0] idx
    );
        logic signed [WEIGHT_W-1:0] w;
        w = '0;
        if (idx <= FEAT_BIAS)
        begin
            w = WEIGHT_ROM[act][idx];
        end
        return w;
    endfunction

endpackage

// ----- rtl/lpd_features.sv -----
module lpd_features #(
    parameter int MAX_HISTORY = lpd_pkg::MAX_HISTORY_DEF,
    parameter int OBS_LANES   = lpd_pkg::OBS_LANES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  lpd_pkg::lpd_in_word_t                in_data,
    input  logic [lpd_pkg::INV_W-1:0]            inv_len,
    input  logic                                 issue,
    input  logic [lpd_pkg::FIDX_W-1:0]           issue_idx,
    output lpd_pkg::lpd_lane_ctrl_t              lane_ctrl,
    output logic signed [lpd_pkg::FEAT_W-1:0]    feat
);
    import lpd_pkg::*;

    localparam logic [CNT_W-1:0] CntCap =
        CNT_W'((MAX_HISTORY < CNT_LIMIT) ? MAX_HISTORY : CNT_LIMIT);

    lpd_in_word_t              word_reg;
    logic [CNT_W-1:0]          comp_reg, comp_next;
    logic [CNT_W-1:0]          chk_reg, chk_next;
    logic [CNT_W:0]            prog;
    logic [CNT_W+INV_W:0]      prog_prod;
    logic signed [FEAT_W-1:0]  obs_arr [8];
    logic [2:0]                obs_sel;
    logic signed [FEAT_W-1:0]  feat_mux;
    logic signed [FEAT_W-1:0]  feat_reg;
    logic [FIDX_W-1:0]         fidx_reg;
    logic                      feat_vld_reg;

    // Apply the history event before the item's features are formed
    always_comb
    begin
        comp_next = comp_reg;
        chk_next  = chk_reg;
        unique case (in_data.history_event) inside
            EV_NEW:
            begin
                comp_next = '0;
                chk_next  = '0;
            end
            EV_PLAIN, EV_CHECK:
            begin
                if (comp_reg < CntCap)
                begin
                    comp_next = comp_reg + 1'b1;
                    if (in_data.history_event == EV_CHECK)
                    begin
                        chk_next = chk_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_reg     <= '0;
            chk_reg      <= '0;
            feat_vld_reg <= 1'b0;
        end
        else
        begin
            feat_vld_reg <= issue;
            if (accept)
            begin
                comp_reg <= comp_next;
                chk_reg  <= chk_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= in_data;
        end
        if (issue)
        begin
            feat_reg <= feat_mux;
            fidx_reg <= issue_idx;
        end
    end

    assign prog      = {1'b0, comp_reg} + 1'b1;
    assign prog_prod = prog * inv_len;

    assign obs_arr[0] = word_reg.obs_0;
    assign obs_arr[1] = word_reg.obs_1;
    assign obs_arr[2] = word_reg.obs_2;
    assign obs_arr[3] = word_reg.obs_3;
    assign obs_arr[4] = word_reg.obs_4;
    assign obs_arr[5] = word_reg.obs_5;
    assign obs_arr[6] = word_reg.obs_6;
    assign obs_arr[7] = word_reg.obs_7;
    assign obs_sel    = 3'(issue_idx - FEAT_OBS0);

    always_comb
    begin
        case (issue_idx) inside
            FEAT_CHECK:    feat_mux = $signed({7'd0, chk_reg, 16'd0});
            FEAT_PROGRESS: feat_mux = $signed({5'd0, prog_prod});
            FEAT_REWARD:   feat_mux = word_reg.episode_reward;
            FEAT_COST:     feat_mux = word_reg.episode_cost;
            [FEAT_OBS0:FEAT_OBS7]:
                feat_mux = (int'(obs_sel) < OBS_LANES) ? obs_arr[obs_sel] : '0;
            FEAT_BIAS:     feat_mux = BIAS_ONE;
            default:       feat_mux = '0;
        endcase
    end

    assign lane_ctrl.clear    = accept;
    assign lane_ctrl.feat_vld = feat_vld_reg;
    assign lane_ctrl.fidx     = fidx_reg;
    assign feat               = feat_reg;

`ifndef SYNTHESIS
    ap_chk_le_comp: assert property (@(posedge clk) disable iff (!rst_n)
        chk_reg <= comp_reg)
        else $error("check count exceeds completed count");
    ap_comp_cap: assert property (@(posedge clk) disable iff (!rst_n)
        comp_reg <= CntCap)
        else $error("completed count beyond its limit");
`endif

endmodule

// ----- rtl/lpd_mac_lane.sv -----
module lpd_mac_lane #(
    parameter int LANE = 0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lpd_pkg::lpd_lane_ctrl_t              ctrl,
    input  logic signed [lpd_pkg::FEAT_W-1:0]    feat,
    output logic                                 busy,
    output logic signed [lpd_pkg::ACC_W-1:0]     acc
);
    import lpd_pkg::*;

    logic signed [WEIGHT_W-1:0] weight;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       prod_vld_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    assign weight = lpd_weight(1'(LANE), ctrl.fidx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.feat_vld;
        end
    end

    // Register the product, then add it into the accumulator
    always_ff @(posedge clk)
    begin
        if (ctrl.feat_vld)
        begin
            prod_reg <= feat * weight;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    assign busy = prod_vld_reg;
    assign acc  = acc_reg;

`ifndef SYNTHESIS
    ap_prod_follows_feat: assert property (@(posedge clk) disable iff (!rst_n)
        prod_vld_reg |-> $past(ctrl.feat_vld))
        else $error("product without a preceding feature");
    ap_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |-> !prod_vld_reg && !ctrl.feat_vld)
        else $error("accumulator cleared while terms in flight");
`endif

endmodule

// ----- rtl/lpd_merge.sv -----
module lpd_merge (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic signed [lpd_pkg::ACC_W-1:0]     acc_pass,
    input  logic signed [lpd_pkg::ACC_W-1:0]     acc_check,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output lpd_pkg::lpd_out_word_t               out_data
);
    import lpd_pkg::*;

    localparam int ExtW = SCORE_W - (ACC_W - FRAC_W);

    logic signed [SCORE_W-1:0] score_pass;
    logic signed [SCORE_W-1:0] score_check;
    logic                      out_valid_reg;
    lpd_out_word_t             out_reg;

    // Floor shift by the fraction width, then widen to the score format
    assign score_pass  = {{ExtW{acc_pass[ACC_W-1]}},  acc_pass[ACC_W-1:FRAC_W]};
    assign score_check = {{ExtW{acc_check[ACC_W-1]}}, acc_check[ACC_W-1:FRAC_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.decision    <= (score_check > score_pass);
            out_reg.score_pass  <= score_pass;
            out_reg.score_check <= score_check;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    ap_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !out_valid_reg || out_ready)
        else $error("result word overwritten before it was taken");
`endif

endmodule

// ----- rtl/linear_policy_decision_unit.sv -----
// Two-action linear policy: each input word carries eight observations,
// the episode reward and cost, and a history event that first updates the
// completed and check counters (a new-episode event clears them). The block
// scores a 13-term feature vector against two fixed weight rows in two MAC
// lanes, one per action, stepping through the features one per cycle, and
// returns the larger score's index (ties go to action 0) with both scores.
// An item goes from acceptance to the result word by these steps: accept,
// 13 feature steps through each lane's single multiplier, emptying the
// multiply and accumulate stages, and loading the output register. The
// next word is taken on the cycle after that load, while the result may
// still wait at the output. inverse_episode_length (unsigned Q1.16) is
// written through cfg_we/cfg_data and should only change while idle.
module linear_policy_decision_unit #(
    parameter int MAX_HISTORY = lpd_pkg::MAX_HISTORY_DEF,
    parameter int OBS_LANES   = lpd_pkg::OBS_LANES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  lpd_pkg::lpd_in_word_t        in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output lpd_pkg::lpd_out_word_t       out_data,
    input  logic                         cfg_we,
    input  logic [lpd_pkg::INV_W-1:0]    cfg_data
);
    import lpd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    logic [FIDX_W-1:0]         idx_reg, idx_next;
    logic [INV_W-1:0]          inv_len_reg;
    logic                      accept;
    logic                      issue;
    logic                      load;
    logic                      pipe_empty;
    lpd_lane_ctrl_t            lane_ctrl;
    logic signed [FEAT_W-1:0]  feat;
    logic [NUM_ACTIONS-1:0]    lane_busy;
    logic signed [ACC_W-1:0]   acc [NUM_ACTIONS];

    // Hold the episode-length reciprocal; writes land whenever enabled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_len_reg <= INV_LEN_RESET;
        end
        else if (cfg_we)
        begin
            inv_len_reg <= cfg_data;
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign issue      = (state_reg == S_RUN);
    assign pipe_empty = !lane_ctrl.feat_vld && !(|lane_busy);
    assign load       = (state_reg == S_DRAIN) && pipe_empty && (!out_valid || out_ready);

    // Sequencer: accept a word, step the features, drain, hand off the result
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                    idx_next   = FEAT_CHECK;
                end
            end
            S_RUN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == FEAT_BIAS)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    lpd_features #(
        .MAX_HISTORY (MAX_HISTORY),
        .OBS_LANES   (OBS_LANES)
    ) u_features (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_data   (in_data),
        .inv_len   (inv_len_reg),
        .issue     (issue),
        .issue_idx (idx_reg),
        .lane_ctrl (lane_ctrl),
        .feat      (feat)
    );

    // One MAC lane per action, all fed the same feature stream
    for (genvar a = 0; a < NUM_ACTIONS; a++)
    begin : g_lane
        lpd_mac_lane #(
            .LANE (a)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl),
            .feat  (feat),
            .busy  (lane_busy[a]),
            .acc   (acc[a])
        );
    end

    lpd_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .acc_pass  (acc[0]),
        .acc_check (acc[1]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    ap_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_RUN && idx_reg == FEAT_CHECK)
        else $error("accepted word did not start the feature sweep");
    ap_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> pipe_empty)
        else $error("lanes still busy while ready for a new word");
    ap_last_feature: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && idx_reg == FEAT_BIAS)
            |=> state_reg == S_DRAIN && lane_ctrl.feat_vld)
        else $error("bias term not issued before draining");
`endif

endmodule
